### rtl/phrt_pkg.sv
// ----------------------------------------------------------------------------
// phrt_pkg
// Shared types and constants of the pulse heart rate tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package phrt_pkg;

  localparam int DIV_W = 16;
  localparam int DVS_W = 12;
  localparam int CNT_W = 12;
  localparam int RATE_W = 8;
  localparam int CFG_AW = 5;

  localparam logic [DIV_W-1:0] RATE_DIVIDEND = 16'd60000;
  localparam logic [RATE_W-1:0] RATE_MAX = 8'd255;

  // register indexes
  localparam logic [2:0] REG_MIN_WIDTH = 3'd0;
  localparam logic [2:0] REG_MIN_INTERVAL = 3'd1;
  localparam logic [2:0] REG_MAX_INTERVAL = 3'd2;
  localparam logic [2:0] REG_SILENCE_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_MAX_STEP = 3'd4;
  localparam logic [2:0] REG_PAIR_TOLERANCE = 3'd5;
  localparam logic [2:0] REG_INIT_LOW = 3'd6;
  localparam logic [2:0] REG_INIT_HIGH = 3'd7;

  // register reset values
  localparam logic [7:0] RST_MIN_WIDTH = 8'd10;
  localparam logic [11:0] RST_MIN_INTERVAL = 12'd250;
  localparam logic [11:0] RST_MAX_INTERVAL = 12'd1500;
  localparam logic [11:0] RST_SILENCE_TIMEOUT = 12'd2000;
  localparam logic [7:0] RST_MAX_STEP = 8'd4;
  localparam logic [7:0] RST_PAIR_TOLERANCE = 8'd6;
  localparam logic [7:0] RST_INIT_LOW = 8'd70;
  localparam logic [7:0] RST_INIT_HIGH = 8'd90;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // result item, heart_rate in the lowest bits
  typedef struct packed {
    logic [5:0] pad;
    logic [RATE_W-1:0] instant_rate_out;
    logic beat_used;
    logic paired;
    logic [RATE_W-1:0] heart_rate;
  } out_item_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV_RATE = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_FILTER = 7'b0001000,
    ST_SHIFT = 7'b0010000,
    ST_DIV_AVG = 7'b0100000,
    ST_OUT = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

### rtl/phrt_div.sv
// ----------------------------------------------------------------------------
// phrt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module phrt_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire phrt_pkg::div_req_t req,
  output phrt_pkg::div_rsp_t     rsp
);
  import phrt_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic busy;
  logic done;
  logic [STEP_W-1:0] step;
  logic [DVS_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0] trial;
  logic fits;
  logic [DVS_W:0] diff;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits = trial >= {1'b0, dvs};
  assign diff = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

### rtl/pulse_heart_rate_tracker.sv
// ----------------------------------------------------------------------------
// pulse_heart_rate_tracker
// Beat detection, rate measurement and averaging filter on a pulse pin.
// ----------------------------------------------------------------------------
// One input item is one pulse pin sample per 1 ms tick; every item gives one
// result item. A tick without an in-range beat goes through the check state. A
// beat inside the interval limits runs 60000/interval on the 16-step divider,
// then the filter state when it locks the filter, or the filter, shift and
// average states when it updates a locked filter, where the history average is
// one reciprocal multiply. The next item is taken once the sequencer is back in
// idle; a finished result waits in the output register, and the next finished
// result holds the sequencer until that one is taken.
`default_nettype none

module pulse_heart_rate_tracker #(
  parameter int HISTORY_DEPTH = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] pin_level
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] heart_rate, [8] paired,
                                      // [9] beat_used, [17:10] instant_rate_out
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import phrt_pkg::*;

  localparam int SUM_W = $clog2(255 * HISTORY_DEPTH + 1);
  // floor(sum / depth) as (sum * AVG_MUL) >> AVG_SH, exact for SUM_W-bit sums
  localparam int AVG_SH = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int AVG_PW = SUM_W + AVG_SH + 1;
  localparam int AVG_MUL = (2 ** AVG_SH + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

  // configuration
  logic [7:0] min_width;
  logic [11:0] min_interval;
  logic [11:0] max_interval;
  logic [11:0] silence_timeout;
  logic [7:0] max_step;
  logic [7:0] pair_tolerance;
  logic [7:0] init_low;
  logic [7:0] init_high;

  // tracking state
  state_t state;
  logic [CNT_W-1:0] interval_count;
  logic [7:0] width_count;
  logic level_seen;
  logic [RATE_W-1:0] filtered_rate;
  logic [RATE_W-1:0] instant_rate;
  logic [RATE_W-1:0] previous_rate;
  logic pair_flag;
  logic beat_flag;
  logic [RATE_W-1:0] slew_rate;
  logic [RATE_W-1:0] rate_history [HISTORY_DEPTH];
  logic [SUM_W-1:0] history_sum;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_take;
  logic out_free;
  logic cfg_write;
  logic pin;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0] wc_inc;
  logic beat;
  logic in_range;
  logic [RATE_W-1:0] rate;
  logic [RATE_W-1:0] rate_diff;
  logic [RATE_W-1:0] clamp_rate;
  logic [RATE_W-1:0] slew_next;
  logic [RATE_W:0] slew_up;
  logic [SUM_W-1:0] sum_new;
  logic [AVG_PW-1:0] avg_prod;
  out_item_t out_item;

  assign pready = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign s_tready = (state == ST_IDLE);
  assign in_take = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign pin = s_tdata[0];

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= RST_MIN_WIDTH;
      min_interval <= RST_MIN_INTERVAL;
      max_interval <= RST_MAX_INTERVAL;
      silence_timeout <= RST_SILENCE_TIMEOUT;
      max_step <= RST_MAX_STEP;
      pair_tolerance <= RST_PAIR_TOLERANCE;
      init_low <= RST_INIT_LOW;
      init_high <= RST_INIT_HIGH;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_MIN_WIDTH: min_width <= pwdata[7:0];
        REG_MIN_INTERVAL: min_interval <= pwdata[11:0];
        REG_MAX_INTERVAL: max_interval <= pwdata[11:0];
        REG_SILENCE_TIMEOUT: silence_timeout <= pwdata[11:0];
        REG_MAX_STEP: max_step <= pwdata[7:0];
        REG_PAIR_TOLERANCE: pair_tolerance <= pwdata[7:0];
        REG_INIT_LOW: init_low <= pwdata[7:0];
        REG_INIT_HIGH: init_high <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MIN_WIDTH: prdata = {24'd0, min_width};
      REG_MIN_INTERVAL: prdata = {20'd0, min_interval};
      REG_MAX_INTERVAL: prdata = {20'd0, max_interval};
      REG_SILENCE_TIMEOUT: prdata = {20'd0, silence_timeout};
      REG_MAX_STEP: prdata = {24'd0, max_step};
      REG_PAIR_TOLERANCE: prdata = {24'd0, pair_tolerance};
      REG_INIT_LOW: prdata = {24'd0, init_low};
      REG_INIT_HIGH: prdata = {24'd0, init_high};
      default: prdata = '0;
    endcase
  end

  // tick front end
  always_comb begin
    cnt_inc = (interval_count != '1) ? interval_count + 1'b1 : interval_count;
    wc_inc = (width_count != 8'hFF) ? width_count + 1'b1 : width_count;
    beat = pin & ~level_seen & (wc_inc > min_width);
    in_range = (cnt_inc <= max_interval) && (cnt_inc >= min_interval);
  end

  // rate from the divider, pairing distance
  always_comb begin
    rate = (div_rsp.quotient[DIV_W-1:RATE_W] != '0) ? RATE_MAX
                                                      : div_rsp.quotient[RATE_W-1:0];
    rate_diff = (rate > previous_rate) ? rate - previous_rate : previous_rate - rate;
  end

  // init window clamp and slew limit
  always_comb begin
    if (instant_rate > init_high) begin
      clamp_rate = init_high;
    end else if (instant_rate < init_low) begin
      clamp_rate = init_low;
    end else begin
      clamp_rate = instant_rate;
    end
    slew_up = {1'b0, filtered_rate} + {1'b0, max_step};
    slew_next = instant_rate;
    if (instant_rate >= filtered_rate) begin
      if (instant_rate - filtered_rate > max_step) begin
        slew_next = slew_up[RATE_W] ? RATE_MAX : slew_up[RATE_W-1:0];
      end
    end else if (filtered_rate - instant_rate > max_step) begin
      slew_next = filtered_rate - max_step;
    end
    sum_new = history_sum - SUM_W'(rate_history[0]) + SUM_W'(slew_rate);
    avg_prod = AVG_PW'(history_sum) * AVG_PW'(AVG_MUL);
  end

  // divider requests
  always_comb begin
    div_req.start = in_take & beat & in_range;
    div_req.dividend = RATE_DIVIDEND;
    div_req.divisor = cnt_inc;
  end

  phrt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      interval_count <= '0;
      width_count <= '0;
      level_seen <= 1'b0;
      filtered_rate <= '0;
      instant_rate <= '0;
      previous_rate <= '0;
      pair_flag <= 1'b0;
      beat_flag <= 1'b0;
      history_sum <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        rate_history[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            beat_flag <= 1'b0;
            if (pin) begin
              if (!level_seen) begin
                if (beat) begin
                  width_count <= '0;
                  level_seen <= 1'b1;
                end else begin
                  width_count <= wc_inc;
                end
              end
            end else begin
              level_seen <= 1'b0;
              width_count <= '0;
            end
            interval_count <= beat ? '0 : cnt_inc;
            if (beat && !in_range && filtered_rate == '0) begin
              previous_rate <= '0;
            end
            state <= (beat && in_range) ? ST_DIV_RATE : ST_CHECK;
          end
        end
        ST_DIV_RATE: begin
          if (div_rsp.done) begin
            instant_rate <= rate;
            previous_rate <= rate;
            if (filtered_rate != '0 || (previous_rate != '0 && rate_diff < pair_tolerance)) begin
              beat_flag <= 1'b1;
              state <= ST_FILTER;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_CHECK: begin
          if (interval_count > silence_timeout) begin
            interval_count <= '0;
            filtered_rate <= '0;
            previous_rate <= '0;
            instant_rate <= '0;
            pair_flag <= 1'b0;
            history_sum <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
              rate_history[i] <= '0;
            end
          end
          state <= ST_OUT;
        end
        ST_FILTER: begin
          pair_flag <= 1'b1;
          if (filtered_rate == '0) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
              rate_history[i] <= clamp_rate;
            end
            history_sum <= SUM_W'(clamp_rate) * SUM_W'(HISTORY_DEPTH);
            filtered_rate <= clamp_rate;
            state <= ST_OUT;
          end else begin
            slew_rate <= slew_next;
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            rate_history[i] <= rate_history[i+1];
          end
          rate_history[HISTORY_DEPTH-1] <= slew_rate;
          history_sum <= sum_new;
          state <= ST_DIV_AVG;
        end
        ST_DIV_AVG: begin
          filtered_rate <= avg_prod[AVG_SH +: RATE_W];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_comb begin
    out_item.pad = '0;
    out_item.instant_rate_out = instant_rate;
    out_item.beat_used = beat_flag;
    out_item.paired = pair_flag;
    out_item.heart_rate = filtered_rate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= out_item;
    end
  end

endmodule

`default_nettype wire

### rtl/phrt_checker.sv
// ----------------------------------------------------------------------------
// phrt_checker
// Port-level checks of the pulse heart rate tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module phrt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);
  import phrt_pkg::*;

  out_item_t item;
  assign item = m_tdata;

  // a nonzero heart rate only while tracking
  a_rate_paired: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && item.heart_rate != '0 |-> item.paired)
    else $error("heart rate reported without pairing");

  // a filter update always comes with a measured rate and pairing
  a_beat_used: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && item.beat_used |-> item.paired && item.instant_rate_out != '0)
    else $error("beat used without pairing or rate");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind pulse_heart_rate_tracker phrt_checker u_phrt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
